FILE: rtl/core/codon_stats_table_macros.svh
// Assertion macros used by the codon statistics table controller.
// Each macro takes a label, the clock, the reset, a condition and its consequence.
`ifndef CODON_STATS_TABLE_MACROS_SVH
`define CODON_STATS_TABLE_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define CST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("codon stats table: assertion failed");

// The consequence must hold in the cycle after the condition.
`define CST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("codon stats table: assertion failed");

`endif

FILE: rtl/core/cst_pkg.sv
// ---------------------------------------------------------------------------
// Codon statistics table package
// Types, codes, constants and lookup functions shared by the table RTL.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int NUM_ENTRIES     = 64;
   localparam int IDX_W           = 6;
   localparam int NUM_GROUPS      = 21;
   localparam int GRP_W           = 5;

   localparam logic [7:0] LETTER_UNKNOWN = "X";
   localparam logic [7:0] LETTER_STOP    = "*";

   // Amino-acid letter of each codon, codon 0 first.
   localparam logic [0:NUM_ENTRIES-1][7:0] LETTER_TABLE = {
      "KNKNTTTTRSRSIIMI",
      "QHQHPPPPRRRRLLLL",
      "EDEDAAAAGGGGVVVV",
      "*Y*YSSSS*CWCLFLF"};

   typedef enum logic [2:0] {
      CMD_CLEAR   = 3'd0,
      CMD_WRITE   = 3'd1,
      CMD_ACCUM   = 3'd2,
      CMD_PAUSE   = 3'd3,
      CMD_READ    = 3'd4,
      CMD_COMPUTE = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [5:0]         codon;
      logic               codon_known;
      logic signed [31:0] count_in;
      logic signed [31:0] value_in;
      logic signed [31:0] score_in;
   } req_type;

   typedef struct packed {
      logic [7:0]         letter;
      logic signed [31:0] count_out;
      logic signed [31:0] value_out;
      logic signed [31:0] score_out;
      logic               found;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SUM_RD,
      ST_SUM_ADD,
      ST_NRM_RD,
      ST_NRM_DIV,
      ST_NRM_WAIT,
      ST_SC_RD,
      ST_SC_DIV,
      ST_SC_WAIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic exec;
      logic cmp_init;
      logic k_clear;
      logic k_inc;
      logic rd_k;
      logic sum_add;
      logic div_start_norm;
      logic div_start_score;
      logic wr_norm;
      logic wr_score;
      logic rsp_compute;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] cmd;
      logic       k_last;
      logic       div_done;
   } sts_type;

   function automatic logic [7:0] letter_of(input logic [IDX_W-1:0] codon);
      return LETTER_TABLE[codon];
   endfunction

   // Group index of a codon: codons with the same letter share a group.
   function automatic logic [GRP_W-1:0] group_of(input logic [IDX_W-1:0] codon);
      logic [GRP_W-1:0] grp;
      unique case (LETTER_TABLE[codon])
         "K":     grp = 5'd0;
         "N":     grp = 5'd1;
         "T":     grp = 5'd2;
         "R":     grp = 5'd3;
         "S":     grp = 5'd4;
         "I":     grp = 5'd5;
         "M":     grp = 5'd6;
         "Q":     grp = 5'd7;
         "H":     grp = 5'd8;
         "P":     grp = 5'd9;
         "L":     grp = 5'd10;
         "E":     grp = 5'd11;
         "D":     grp = 5'd12;
         "A":     grp = 5'd13;
         "G":     grp = 5'd14;
         "V":     grp = 5'd15;
         "Y":     grp = 5'd16;
         "C":     grp = 5'd17;
         "W":     grp = 5'd18;
         "F":     grp = 5'd19;
         default: grp = 5'd20;
      endcase
      return grp;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/codon_stats_table.sv
// ---------------------------------------------------------------------------
// Codon statistics table
// A 64-entry table of count, value and score per codon, with saturating
// updates and a relative adaptiveness computation.
// ---------------------------------------------------------------------------
// Usage: drive req_item and raise start; the transaction is taken at a rising
// edge where start is high and busy is low. Every transaction gives exactly
// one result on rsp_item, marked by rsp_strobe for one cycle; the receiver
// must take it then, as it cannot hold results off.
// Clear, write, accumulate, pausing update, read and the unused codes are
// single-entry transactions: the entry memories are read at the accept edge
// and the read-modify-write lands in the next cycle. The result is registered
// from that cycle, and a new transaction may be accepted while it is shown.
// Compute walks all 64 entries three times: a summing pass that reads and
// adds each entry, then a normalizing and a scoring pass, each limited by
// the bit-serial divider. Clear takes effect at once through per-entry
// valid bits; reset clears them too, so the table reads as all zero after
// reset without a clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module codon_stats_table #(
   parameter int VALUE_WIDTH = cst_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = cst_pkg::FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cst_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output cst_pkg::rsp_type      rsp_item
);

   import cst_pkg::*;

   ctl_type ctl;
   sts_type sts;

   cst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   cst_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

FILE: rtl/core/cst_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/cst_div.sv
// ---------------------------------------------------------------------------
// Fixed-point divider
// Bit-serial restoring divider giving (num * 2^FB) / den, truncated toward
// zero and saturated to the signed VW range; a zero divisor gives zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cst_div #(
   parameter int VW = 32,
   parameter int FB = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [VW-1:0] num,
   input  wire logic signed [VW-1:0] den,
   output logic                      done,
   output logic signed [VW-1:0]      quot
);

   localparam int NW = VW + FB;
   localparam int CW = $clog2(NW + 1);
   localparam logic [NW-1:0] LIM_POS = {{(FB + 1){1'b0}}, {(VW - 1){1'b1}}};
   localparam logic [NW-1:0] LIM_NEG = LIM_POS + NW'(1);

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff,  cnt_in;
   logic [VW-1:0]     rem_ff,  rem_in;
   logic [NW-1:0]     sh_ff,   sh_in;
   logic [VW-1:0]     ud_ff,   ud_in;
   logic              neg_ff,  neg_in;
   logic              zero_ff, zero_in;
   logic [VW-1:0]     quot_ff, quot_in;

   logic [VW-1:0]     un;
   logic [VW:0]       rem_sh;
   logic [VW+1:0]     diff;
   logic              ge;
   logic [NW-1:0]     limit;
   logic [NW-1:0]     qsat;

   // Magnitude of the dividend; the divisor's magnitude is captured at start.
   assign un = num[VW-1] ? VW'(-num) : VW'(num);

   // One quotient bit per cycle.
   assign rem_sh = {rem_ff, sh_ff[NW-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, ud_ff};
   assign ge     = ~diff[VW+1];

   // Saturate the magnitude; a negative result may reach one step further.
   assign limit = neg_ff ? LIM_NEG : LIM_POS;
   assign qsat  = (sh_ff > limit) ? limit : sh_ff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      ud_in   = ud_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      quot_in = quot_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = CW'(NW);
         rem_in  = '0;
         sh_in   = {un, {FB{1'b0}}};
         ud_in   = den[VW-1] ? VW'(-den) : VW'(den);
         neg_in  = num[VW-1] ^ den[VW-1];
         zero_in = (den == '0);
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            if (zero_ff) begin
               quot_in = '0;
            end else if (neg_ff) begin
               quot_in = VW'(-qsat[VW-1:0]);
            end else begin
               quot_in = qsat[VW-1:0];
            end
         end else begin
            cnt_in = cnt_ff - CW'(1);
            rem_in = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
            sh_in  = {sh_ff[NW-2:0], ge};
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      ud_ff   <= ud_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

FILE: rtl/core/cst_ctrl.sv
// ---------------------------------------------------------------------------
// Codon statistics table controller
// Sequences single-entry commands and the multi-pass compute walk.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "codon_stats_table_macros.svh"

module cst_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cst_pkg::sts_type sts,
   output cst_pkg::ctl_type      ctl
);

   import cst_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.cmd == CMD_COMPUTE) begin
               ctl.cmp_init = 1'b1;
               ctl.k_clear  = 1'b1;
               state_in     = ST_SUM_RD;
            end else begin
               ctl.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SUM_RD: begin
            ctl.rd_k = 1'b1;
            state_in = ST_SUM_ADD;
         end
         ST_SUM_ADD: begin
            ctl.sum_add = 1'b1;
            if (sts.k_last) begin
               ctl.k_clear = 1'b1;
               state_in    = ST_NRM_RD;
            end else begin
               ctl.k_inc = 1'b1;
               state_in  = ST_SUM_RD;
            end
         end
         ST_NRM_RD: begin
            ctl.rd_k = 1'b1;
            state_in = ST_NRM_DIV;
         end
         ST_NRM_DIV: begin
            ctl.div_start_norm = 1'b1;
            state_in           = ST_NRM_WAIT;
         end
         ST_NRM_WAIT: begin
            if (sts.div_done) begin
               ctl.wr_norm = 1'b1;
               if (sts.k_last) begin
                  ctl.k_clear = 1'b1;
                  state_in    = ST_SC_RD;
               end else begin
                  ctl.k_inc = 1'b1;
                  state_in  = ST_NRM_RD;
               end
            end
         end
         ST_SC_RD: begin
            ctl.rd_k = 1'b1;
            state_in = ST_SC_DIV;
         end
         ST_SC_DIV: begin
            ctl.div_start_score = 1'b1;
            state_in            = ST_SC_WAIT;
         end
         ST_SC_WAIT: begin
            if (sts.div_done) begin
               ctl.wr_score = 1'b1;
               if (sts.k_last) begin
                  ctl.rsp_compute = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  ctl.k_inc = 1'b1;
                  state_in  = ST_SC_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // A divider result only arrives while the walk waits for it.
   `CST_ASSERT_NOW(a_done_in_wait, clock, reset, sts.div_done,
      (state_ff == ST_NRM_WAIT) || (state_ff == ST_SC_WAIT))
   // An accepted transaction is executed in the next cycle.
   `CST_ASSERT_NEXT(a_accept_exec, clock, reset, ctl.accept, state_ff == ST_EXEC)
   // A compute transaction starts with the summing pass.
   `CST_ASSERT_NEXT(a_compute_sum, clock, reset, ctl.cmp_init, state_ff == ST_SUM_RD)

endmodule

`default_nettype wire

FILE: rtl/core/cst_dpath.sv
// ---------------------------------------------------------------------------
// Codon statistics table datapath
// Entry memories, valid bits, saturating arithmetic, the divider and the
// registered result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cst_dpath #(
   parameter int VALUE_WIDTH = cst_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = cst_pkg::FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cst_pkg::req_type req_item,
   input  wire cst_pkg::ctl_type ctl,
   output cst_pkg::sts_type      sts,
   output logic                  rsp_strobe,
   output cst_pkg::rsp_type      rsp_item
);

   import cst_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int XW = VW + 33;
   localparam logic signed [XW-1:0] VMAX = {{(XW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
   localparam logic signed [XW-1:0] VMIN = ~VMAX;
   localparam logic signed [XW-1:0] CMAX = {{(XW - 31){1'b0}}, {31{1'b1}}};
   localparam logic signed [XW-1:0] CMIN = ~CMAX;

   function automatic logic signed [VW-1:0] sat_vw(input logic signed [XW-1:0] x);
      if (x > VMAX) begin
         return VMAX[VW-1:0];
      end else if (x < VMIN) begin
         return VMIN[VW-1:0];
      end
      return x[VW-1:0];
   endfunction

   function automatic logic signed [31:0] sat_c(input logic signed [XW-1:0] x);
      if (x > CMAX) begin
         return CMAX[31:0];
      end else if (x < CMIN) begin
         return CMIN[31:0];
      end
      return x[31:0];
   endfunction

   req_type                 req_ff;
   logic [IDX_W-1:0]        k_ff,     k_in;
   logic [NUM_ENTRIES-1:0]  valid_ff, valid_in;
   logic                    vld_rd_ff;
   logic signed [VW-1:0]    total_ff, total_in;
   logic signed [VW-1:0]    gmax_ff [NUM_GROUPS];
   logic [NUM_GROUPS-1:0]   gvld_ff;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_ff,   rsp_in;

   logic [IDX_W-1:0]        raddr, waddr;
   logic                    rd_en, we, known;
   logic [GRP_W-1:0]        grp_k;
   logic signed [31:0]      cnt_rd, cnt_cur, cnt_wd;
   logic signed [VW-1:0]    val_rd, val_cur, val_wd;
   logic signed [VW-1:0]    scr_rd, scr_cur, scr_wd;
   logic signed [XW-1:0]    cnt_x, val_x, scr_x;
   logic signed [VW-1:0]    vin_s, sin_s;
   logic signed [VW-1:0]    div_den, quot;
   logic                    div_done;

   assign known = req_ff.codon_known;
   assign grp_k = group_of(k_ff);

   // Memory addressing: the accept cycle reads at the incoming codon.
   assign raddr = ctl.accept ? req_item.codon : k_ff;
   assign rd_en = ctl.accept | ctl.rd_k;
   assign waddr = ctl.exec ? req_ff.codon : k_ff;

   // Entries never written since a clear read as zero.
   assign cnt_cur = vld_rd_ff ? cnt_rd : '0;
   assign val_cur = vld_rd_ff ? val_rd : '0;
   assign scr_cur = vld_rd_ff ? scr_rd : '0;
   assign cnt_x   = XW'(cnt_cur);
   assign val_x   = XW'(val_cur);
   assign scr_x   = XW'(scr_cur);
   assign vin_s   = sat_vw(XW'($signed(req_ff.value_in)));
   assign sin_s   = sat_vw(XW'($signed(req_ff.score_in)));

   // Write data and enable for the three entry memories.
   always_comb begin
      we     = 1'b0;
      cnt_wd = cnt_cur;
      val_wd = val_cur;
      scr_wd = scr_cur;
      if (ctl.wr_norm) begin
         we     = 1'b1;
         val_wd = quot;
      end else if (ctl.wr_score) begin
         we     = 1'b1;
         scr_wd = quot;
      end else if (ctl.exec && known) begin
         unique case (req_ff.command)
            CMD_WRITE: begin
               we     = 1'b1;
               cnt_wd = req_ff.count_in;
               val_wd = vin_s;
               scr_wd = sin_s;
            end
            CMD_ACCUM: begin
               we     = 1'b1;
               cnt_wd = sat_c(cnt_x + XW'($signed(req_ff.count_in)));
               val_wd = sat_vw(val_x + XW'(vin_s));
               scr_wd = sat_vw(scr_x + XW'(sin_s));
            end
            CMD_PAUSE: begin
               we     = 1'b1;
               cnt_wd = sat_c(cnt_x + XW'(1));
               val_wd = (vin_s < val_cur) ? vin_s : val_cur;
               scr_wd = (vin_s > scr_cur) ? vin_s : scr_cur;
            end
            default: begin
               we = 1'b0;
            end
         endcase
      end
   end

   cst_ram #(.WIDTH(32), .DEPTH(NUM_ENTRIES)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (cnt_wd),
      .rd_en   (rd_en),
      .rd_addr (raddr),
      .rd_data (cnt_rd)
   );

   cst_ram #(.WIDTH(VW), .DEPTH(NUM_ENTRIES)) u_val_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (val_wd),
      .rd_en   (rd_en),
      .rd_addr (raddr),
      .rd_data (val_rd)
   );

   cst_ram #(.WIDTH(VW), .DEPTH(NUM_ENTRIES)) u_scr_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (scr_wd),
      .rd_en   (rd_en),
      .rd_addr (raddr),
      .rd_data (scr_rd)
   );

   // Divider: normalize by the total, then score by the group maximum.
   assign div_den = ctl.div_start_score ? gmax_ff[grp_k] : total_ff;

   cst_div #(.VW(VW), .FB(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.div_start_norm | ctl.div_start_score),
      .num   (val_cur),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   // Entry index and valid bits.
   always_comb begin
      k_in     = k_ff;
      valid_in = valid_ff;
      if (ctl.k_clear) begin
         k_in = '0;
      end else if (ctl.k_inc) begin
         k_in = k_ff + IDX_W'(1);
      end
      if (ctl.exec && (req_ff.command == CMD_CLEAR)) begin
         valid_in = '0;
      end else if (we) begin
         valid_in[waddr] = 1'b1;
      end
   end

   // Running total of all values, saturated after each addition.
   always_comb begin
      total_in = total_ff;
      if (ctl.cmp_init) begin
         total_in = '0;
      end else if (ctl.sum_add) begin
         total_in = sat_vw(XW'(total_ff) + val_x);
      end
   end

   // Result of a single-entry transaction or of the compute walk.
   always_comb begin
      rsp_in = '0;
      if (ctl.exec) begin
         unique case (req_ff.command) inside
            CMD_WRITE, CMD_ACCUM, CMD_PAUSE, CMD_READ: begin
               rsp_in.letter = known ? letter_of(req_ff.codon) : LETTER_UNKNOWN;
               rsp_in.found  = known;
            end
            default: begin
               rsp_in.found = 1'b0;
            end
         endcase
         if ((req_ff.command == CMD_READ) && known) begin
            rsp_in.count_out = cnt_cur;
            rsp_in.value_out = sat_c(val_x);
            rsp_in.score_out = sat_c(scr_x);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff          <= '0;
         valid_ff      <= '0;
         gvld_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         k_ff          <= k_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= ctl.exec | ctl.rsp_compute;
         if (ctl.cmp_init) begin
            gvld_ff <= '0;
         end else if (ctl.wr_norm) begin
            gvld_ff[grp_k] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         req_ff <= req_item;
      end
      if (rd_en) begin
         vld_rd_ff <= valid_ff[raddr];
      end
      total_ff <= total_in;
      rsp_ff   <= rsp_in;
      if (ctl.wr_norm && (!gvld_ff[grp_k] || (quot > gmax_ff[grp_k]))) begin
         gmax_ff[grp_k] <= quot;
      end
   end

   assign sts.cmd      = req_ff.command;
   assign sts.k_last   = (k_ff == IDX_W'(NUM_ENTRIES - 1));
   assign sts.div_done = div_done;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_item     = rsp_ff;

endmodule

`default_nettype wire

FILE: bench/codon_stats_table_tb.sv
// ---------------------------------------------------------------------------
// Codon statistics table testbench
// Drives table commands through the start/busy handshake and checks every
// result strobe against a local model of the 64-entry table. A short table
// of directed transactions comes first, then random command sequences.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module codon_stats_table_tb;
   import cst_pkg::*;

   localparam int     NUM_RANDOM  = 740;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam longint CNT_HI = 64'sd2147483647;
   localparam longint CNT_LO = -64'sd2147483648;

   // Directed stimulus row: the expected result is typed in where has_rsp is set.
   typedef struct {
      req_type req;
      bit      has_rsp;
      rsp_type rsp;
   } step_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Local copy of the table state.
   longint tbl_count [NUM_ENTRIES];
   longint tbl_value [NUM_ENTRIES];
   longint tbl_score [NUM_ENTRIES];

   rsp_type      pending_rsp[$];
   int           mismatch_count = 0;
   int           rsp_seen = 0;
   int           sent_count = 0;
   int           compute_count = 0;
   longint       cycle_count = 0;
   step_row_type directed_rows[$];

   codon_stats_table u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #1 clock = ~clock;

   function automatic longint sat_sum(input longint a, input longint b,
                                      input longint lo, input longint hi);
      longint s;
      s = a + b;
      if (s > hi) return hi;
      if (s < lo) return lo;
      return s;
   endfunction

   // Fixed-point quotient, truncated toward zero and saturated to 32 bits.
   function automatic longint fix_quotient(input longint n, input longint d);
      longint q;
      if (d == 0) return 0;
      q = (n * 65536) / d;
      if (q > CNT_HI) return CNT_HI;
      if (q < CNT_LO) return CNT_LO;
      return q;
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         tbl_count[i] = 0;
         tbl_value[i] = 0;
         tbl_score[i] = 0;
      end
   endfunction

   function automatic void compute_adaptiveness();
      longint total;
      longint best;
      total = 0;
      for (int i = 0; i < NUM_ENTRIES; i++)
         total = sat_sum(total, tbl_value[i], CNT_LO, CNT_HI);
      for (int i = 0; i < NUM_ENTRIES; i++)
         tbl_value[i] = fix_quotient(tbl_value[i], total);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         best = tbl_value[i];
         for (int j = 0; j < NUM_ENTRIES; j++)
            if (LETTER_TABLE[j] == LETTER_TABLE[i] && tbl_value[j] > best)
               best = tbl_value[j];
         tbl_score[i] = fix_quotient(tbl_value[i], best);
      end
   endfunction

   // Applies one transaction to the local table and returns its result.
   function automatic rsp_type table_response(input req_type r);
      rsp_type o;
      int      k;
      longint  z;
      bit      addressed;
      o = '0;
      k = r.codon;
      z = r.value_in;
      addressed = (r.command >= CMD_WRITE) && (r.command <= CMD_READ);
      if (addressed) begin
         o.letter = r.codon_known ? LETTER_TABLE[k] : LETTER_UNKNOWN;
         o.found  = r.codon_known;
      end
      case (r.command)
         CMD_CLEAR: clear_table();
         CMD_WRITE: if (r.codon_known) begin
            tbl_count[k] = r.count_in;
            tbl_value[k] = r.value_in;
            tbl_score[k] = r.score_in;
         end
         CMD_ACCUM: if (r.codon_known) begin
            tbl_count[k] = sat_sum(tbl_count[k], r.count_in, CNT_LO, CNT_HI);
            tbl_value[k] = sat_sum(tbl_value[k], r.value_in, CNT_LO, CNT_HI);
            tbl_score[k] = sat_sum(tbl_score[k], r.score_in, CNT_LO, CNT_HI);
         end
         CMD_PAUSE: if (r.codon_known) begin
            tbl_count[k] = sat_sum(tbl_count[k], 1, CNT_LO, CNT_HI);
            if (z > tbl_score[k]) tbl_score[k] = z;
            if (z < tbl_value[k]) tbl_value[k] = z;
         end
         CMD_READ: if (r.codon_known) begin
            o.count_out = 32'(tbl_count[k]);
            o.value_out = 32'(tbl_value[k]);
            o.score_out = 32'(tbl_score[k]);
         end
         CMD_COMPUTE: compute_adaptiveness();
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_type make_req(input logic [2:0] cmd, input int codon,
                                        input bit known, input logic [31:0] c,
                                        input logic [31:0] v, input logic [31:0] s);
      req_type r;
      r.command     = cmd;
      r.codon       = 6'(codon);
      r.codon_known = known;
      r.count_in    = c;
      r.value_in    = v;
      r.score_in    = s;
      return r;
   endfunction

   function automatic rsp_type make_rsp(input logic [7:0] l, input logic [31:0] c,
                                        input logic [31:0] v, input logic [31:0] s,
                                        input bit f);
      rsp_type o;
      o.letter    = l;
      o.count_out = c;
      o.value_out = v;
      o.score_out = s;
      o.found     = f;
      return o;
   endfunction

   function automatic void add_row(input req_type r, input bit typed, input rsp_type o);
      step_row_type row;
      row.req     = r;
      row.has_rsp = typed;
      row.rsp     = o;
      directed_rows.push_back(row);
   endfunction

   // Random data word, biased toward the extremes and small values.
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 32'h0003_0000);
         3: return -$urandom_range(0, 32'h0003_0000);
         default: return $urandom;
      endcase
   endfunction

   // Random transaction: mostly known codons and table commands, some noise.
   function automatic req_type rand_req();
      logic [2:0] cmd;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)      cmd = CMD_WRITE;
      else if (pick < 45) cmd = CMD_ACCUM;
      else if (pick < 60) cmd = CMD_PAUSE;
      else if (pick < 88) cmd = CMD_READ;
      else if (pick < 92) cmd = CMD_COMPUTE;
      else if (pick < 95) cmd = CMD_CLEAR;
      else                cmd = 3'($urandom_range(6, 7));
      return make_req(cmd, $urandom_range(0, 63), ($urandom_range(0, 9) != 0),
                      rand_word(), rand_word(), rand_word());
   endfunction

   // Issues one transaction after a random gap and records its expectation.
   // The cycle right after an accept is always busy, so start is held high
   // until busy falls and is lowered before the next gap.
   task automatic send_req(input req_type r, input bit typed, input rsp_type o);
      rsp_type predicted;
      int      gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      repeat (gap + 1) @(posedge clock);
      predicted = table_response(r);
      pending_rsp.push_back(typed ? o : predicted);
      if (r.command == CMD_COMPUTE) compute_count++;
      req_item <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      sent_count++;
   endtask

   // Compare each result strobe with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result %h", rsp_item);
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_item !== e) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: result mismatch: expected %h, actual %h", e, rsp_item);
            end
         end
      end
   end

   // Cycle counter and run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int drain;
      clear_table();
      // Directed table: extremes, every command, unknown codons, unused codes.
      add_row(make_req(CMD_READ, 0, 1, 0, 0, 0), 1, make_rsp("K", 0, 0, 0, 1));
      add_row(make_req(CMD_READ, 63, 1, 0, 0, 0), 1, make_rsp("F", 0, 0, 0, 1));
      add_row(make_req(CMD_WRITE, 14, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
              1, make_rsp("M", 0, 0, 0, 1));
      add_row(make_req(CMD_READ, 14, 1, 0, 0, 0), 1,
              make_rsp("M", 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1));
      add_row(make_req(CMD_ACCUM, 14, 1, 1, 32'hFFFF_FFFF, 5), 0, '0);
      add_row(make_req(CMD_READ, 14, 1, 0, 0, 0), 1,
              make_rsp("M", 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1));
      add_row(make_req(CMD_WRITE, 48, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
              1, make_rsp(LETTER_STOP, 0, 0, 0, 1));
      add_row(make_req(CMD_ACCUM, 48, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF), 0, '0);
      add_row(make_req(CMD_READ, 48, 1, 0, 0, 0), 1,
              make_rsp(LETTER_STOP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1));
      add_row(make_req(CMD_WRITE, 5, 0, 7, 7, 7), 1, make_rsp("X", 0, 0, 0, 0));
      add_row(make_req(CMD_ACCUM, 5, 0, 7, 7, 7), 1, make_rsp("X", 0, 0, 0, 0));
      add_row(make_req(CMD_PAUSE, 5, 0, 7, 7, 7), 1, make_rsp("X", 0, 0, 0, 0));
      add_row(make_req(CMD_READ, 5, 0, 7, 7, 7), 1, make_rsp("X", 0, 0, 0, 0));
      add_row(make_req(CMD_READ, 5, 1, 0, 0, 0), 1, make_rsp("T", 0, 0, 0, 1));
      add_row(make_req(CMD_PAUSE, 5, 1, 0, 32'h0002_0000, 0), 0, '0);
      add_row(make_req(CMD_PAUSE, 5, 1, 0, 32'hFFFF_0000, 0), 0, '0);
      add_row(make_req(CMD_READ, 5, 1, 0, 0, 0), 0, '0);
      add_row(make_req(3'd6, 5, 1, 1, 1, 1), 1, make_rsp(0, 0, 0, 0, 0));
      add_row(make_req(3'd7, 5, 1, 1, 1, 1), 1, make_rsp(0, 0, 0, 0, 0));
      add_row(make_req(CMD_WRITE, 6, 1, 3, 32'h0001_0000, 0), 0, '0);
      add_row(make_req(CMD_WRITE, 7, 1, 4, 32'h0003_0000, 0), 0, '0);
      add_row(make_req(CMD_COMPUTE, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, 0));
      add_row(make_req(CMD_READ, 6, 1, 0, 0, 0), 0, '0);
      add_row(make_req(CMD_CLEAR, 0, 1, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, 0));
      add_row(make_req(CMD_READ, 14, 1, 0, 0, 0), 1, make_rsp("M", 0, 0, 0, 1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_req(directed_rows[i].req, directed_rows[i].has_rsp, directed_rows[i].rsp);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         // Hold off once mid-run until every result is back.
         if (n == NUM_RANDOM / 2)
            while (pending_rsp.size() != 0) @(posedge clock);
         send_req(rand_req(), 0, '0);
      end

      drain = 0;
      while (pending_rsp.size() != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         mismatch_count++;
         $display("ERROR: %0d results never arrived", pending_rsp.size());
      end

      $display("Sent %0d transactions (%0d compute passes), checked %0d results.",
               sent_count, compute_count, rsp_seen);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
